// ----- hw/rtl/array_list_engine_unit_defines.svh -----
// assertion macros shared by the checker
`ifndef ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ALE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ALE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/ale_pkg.sv -----
// package for the array list engine: sizes, codes and word types
package ale_pkg;
    localparam int MaxEntries = 32;
    localparam int ValueWidth = 32;
    localparam int CntW = $clog2(MaxEntries + 1);
    localparam int IdxW = $clog2(MaxEntries);

    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_INSERT = 3'd1;
    localparam logic [2:0] FUNC_DELETE = 3'd2;
    localparam logic [2:0] FUNC_LOCATE = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;
    localparam logic [2:0] FUNC_SORT   = 3'd5;
    localparam logic [2:0] FUNC_DEDUPE = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef logic signed [ValueWidth-1:0] t_val;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic          ins;    // shift right from pos, load at pos
        logic          del;    // shift left from pos
        logic          swap;   // odd-even transposition step
        logic          parity; // which pairs swap
        logic [IdxW:0] pos;    // 0-based index
        t_val          val;
    } t_cell_cmd;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic [5:0]         position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         found_position;
        logic               found;
        logic signed [31:0] read_value;
        logic [5:0]         length;
        logic               is_empty;
        logic               is_full;
    } t_out_word;
endpackage

// ----- hw/rtl/ale_cell.sv -----
// one list cell: holds an entry and takes its neighbor's entry on a shift
module ale_cell import ale_pkg::*; (
    input  logic              i_clk,
    input  logic [IdxW-1:0]   i_idx,
    input  t_cell_cmd         i_cmd,
    input  t_val              i_left,
    input  t_val              i_right,
    output t_val              o_val
);
    t_val r_val;
    t_val n_val;
    logic [IdxW:0] w_idx;
    logic w_lo;
    logic w_hi;

    assign w_idx = {1'b0, i_idx};
    // pair partner for transposition: low member when idx parity matches;
    // during a sort pos carries the length, so only held entries pair up
    assign w_lo = (i_idx[0] == i_cmd.parity) &&
                  ((w_idx + (IdxW+1)'(1)) < i_cmd.pos);
    assign w_hi = (i_idx[0] != i_cmd.parity) && (i_idx != '0) &&
                  (w_idx < i_cmd.pos);

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (w_idx == i_cmd.pos) begin
                n_val = i_cmd.val;
            end else if (w_idx > i_cmd.pos) begin
                n_val = i_left;
            end
        end else if (i_cmd.del) begin
            if (w_idx >= i_cmd.pos) begin
                n_val = i_right;
            end
        end else if (i_cmd.swap) begin
            if (w_lo && (r_val > i_right)) begin
                n_val = i_right;
            end else if (w_hi && (i_left > r_val)) begin
                n_val = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

// ----- hw/rtl/array_list_engine_unit.sv -----
// top level of the array list engine: control sequencer and row of cells
// Usage: raise start with i_in for one cycle while busy is low; the word
// is taken at that edge. Exactly one result word follows on o_out, marked by
// o_done for one cycle. Clear, insert, delete, locate and read finish in one
// cycle: o_done rises on the edge after acceptance and busy stays low, so a
// new word may be taken every cycle. Sort runs odd-even transposition over the
// held cells for MaxEntries steps and then a finishing state, with busy high
// throughout. Dedupe walks the list one entry a cycle, removing each entry
// that repeats a kept one with a delete shift, then passes a state that sees
// the end of the list and the finishing state, with busy high throughout.
// In both cases o_done rises on the edge that drops busy.
// Reset empties the list; cell contents stay undefined until written, but
// only positions below the length are ever read.
// The receiver cannot stall: each result is marked by o_done for one cycle only.
// Locate compares every held cell against the value in parallel and picks the
// first match with a priority search over the row.
module array_list_engine_unit import ale_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_done,
    output t_out_word o_out
);
    typedef enum logic [1:0] {S_IDLE, S_SORT, S_DEDUP_CMP, S_DEDUP_DONE} t_state;

    t_state          r_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_step;
    logic [CntW-1:0] r_kept;
    logic [CntW-1:0] r_scan;
    logic            r_done;
    logic            n_done;
    t_out_word       r_out;
    t_out_word       n_out;
    t_cell_cmd       w_cmd;
    t_val            w_vals [MaxEntries];
    logic [CntW-1:0] w_len1;
    logic            w_acc;
    logic [CntW-1:0] w_fpos;
    logic            w_found;
    logic            w_seen;
    t_val            w_scan_val;
    logic [CntW-1:0] w_pos;
    t_val            w_ival;

    assign w_acc  = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign w_pos  = CntW'(i_in.position);
    assign w_ival = t_val'(i_in.value);
    assign w_len1 = r_count + 1'b1;

    genvar g;
    generate
        for (g = 0; g < MaxEntries; g++) begin : g_cell
            t_val w_l;
            t_val w_r;
            if (g == 0) begin : g_l0
                assign w_l = w_vals[g];
            end else begin : g_ln
                assign w_l = w_vals[g-1];
            end
            if (g == MaxEntries - 1) begin : g_rn
                assign w_r = w_vals[g];
            end else begin : g_r0
                assign w_r = w_vals[g+1];
            end
            ale_cell u_cell (
                .i_clk  (i_clk),
                .i_idx  (IdxW'(g)),
                .i_cmd  (w_cmd),
                .i_left (w_l),
                .i_right(w_r),
                .o_val  (w_vals[g])
            );
        end
    endgenerate

    // first match among held cells, and repeat test for the dedupe scan
    assign w_scan_val = w_vals[r_scan[IdxW-1:0]];
    always_comb begin
        w_fpos  = w_len1;
        w_found = 1'b0;
        w_seen  = 1'b0;
        for (int k = MaxEntries - 1; k >= 0; k--) begin
            if ((CntW'(k) < r_count) && (w_vals[k] == w_ival)) begin
                w_fpos  = CntW'(k + 1);
                w_found = 1'b1;
            end
            if ((CntW'(k) < r_kept) && (w_vals[k] == w_scan_val)) begin
                w_seen = 1'b1;
            end
        end
    end

    always_comb begin
        w_cmd        = '0;
        w_cmd.val    = w_ival;
        w_cmd.parity = r_step[0];
        if (r_state == S_IDLE && w_acc) begin
            w_cmd.pos = (IdxW+1)'(w_pos - 1'b1);
            unique case (i_in.func)
                FUNC_INSERT: w_cmd.ins = (r_count < CntW'(MaxEntries)) &&
                                         (w_pos != '0) && (w_pos <= w_len1);
                FUNC_DELETE: w_cmd.del = (r_count != '0) && (w_pos != '0) &&
                                         (w_pos <= r_count);
                default: ;
            endcase
        end else if (r_state == S_SORT) begin
            // length bounds the swaps to held entries
            w_cmd.swap = 1'b1;
            w_cmd.pos  = (IdxW+1)'(r_count);
        end else if (r_state == S_DEDUP_CMP && r_scan < r_count) begin
            // shift the scanned entry out when it repeats a kept one
            w_cmd.del = w_seen;
            w_cmd.pos = (IdxW+1)'(r_scan);
        end
    end

    // result word for a command taken this cycle
    always_comb begin
        n_out = '0;
        unique case (i_in.func)
            FUNC_INSERT: begin
                if (r_count >= CntW'(MaxEntries)) begin
                    n_out.status = ST_FULL;
                end else if (!w_cmd.ins) begin
                    n_out.status = ST_INVAL;
                end
            end
            FUNC_DELETE: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else if (!w_cmd.del) begin
                    n_out.status = ST_INVAL;
                end
            end
            FUNC_LOCATE: begin
                n_out.found_position = 6'(w_fpos);
                n_out.found          = w_found;
            end
            FUNC_READ: begin
                if (w_pos == '0 || w_pos > r_count) begin
                    n_out.status = ST_INVAL;
                end else begin
                    n_out.read_value = 32'(w_vals[IdxW'(w_pos - 1'b1)]);
                end
            end
            default: ;
        endcase
    end

    assign n_done = (w_acc && i_in.func != FUNC_SORT && i_in.func != FUNC_DEDUPE) ||
                    (r_state == S_DEDUP_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_step  <= '0;
            r_kept  <= '0;
            r_scan  <= '0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out <= n_out;
                        unique case (i_in.func)
                            FUNC_CLEAR: r_count <= '0;
                            FUNC_INSERT: begin
                                if (w_cmd.ins) begin
                                    r_count <= w_len1;
                                end
                            end
                            FUNC_DELETE: begin
                                if (w_cmd.del) begin
                                    r_count <= r_count - 1'b1;
                                end
                            end
                            FUNC_SORT: begin
                                r_step  <= '0;
                                r_state <= S_SORT;
                            end
                            FUNC_DEDUPE: begin
                                r_kept  <= '0;
                                r_scan  <= '0;
                                r_state <= S_DEDUP_CMP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SORT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == CntW'(MaxEntries - 1)) begin
                        r_state <= S_DEDUP_DONE;
                    end
                end
                S_DEDUP_CMP: begin
                    if (r_scan >= r_count) begin
                        r_state <= S_DEDUP_DONE;
                    end else if (w_seen) begin
                        r_count <= r_count - 1'b1;
                    end else begin
                        r_kept <= r_kept + 1'b1;
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DEDUP_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_out          = r_out;
        o_out.length   = 6'(r_count);
        o_out.is_empty = (r_count == '0);
        o_out.is_full  = (r_count >= CntW'(MaxEntries));
        o_done         = r_done;
    end
endmodule

// ----- hw/rtl/ale_checker.sv -----
// port-level checker for the array list engine, bound to the top level
`include "array_list_engine_unit_defines.svh"
module ale_checker import ale_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_in,
    input logic      o_done,
    input t_out_word o_out
);
    `ALE_ASSERT_IMP(a_len_range, i_clk, i_rst_n, 1'b1, o_out.length <= 6'(MaxEntries))
    `ALE_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, 1'b1, o_out.is_empty == (o_out.length == 6'd0))
    `ALE_ASSERT_NXT(a_quick_done, i_clk, i_rst_n, start && !busy && i_in.func != FUNC_SORT && i_in.func != FUNC_DEDUPE, o_done)
    `ALE_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, o_done && o_out.found, o_out.found_position <= o_out.length)
endmodule

bind array_list_engine_unit ale_checker u_ale_checker (.*);
